// ----- rtl/core/rtd_pkg.sv -----
// Shared widths, types and register codes for the ray / triangle displacement block.
// Depends on nothing; used by rtd_div_pipe, ray_triangle_displacement, rtd_checker and tb_top.
`default_nettype none

package rtd_pkg;

   // Input coordinate format and configuration register sizes.
   localparam int COORD_W    = 20;
   localparam int EPS_W      = 20;
   localparam int PULL_W     = 12;
   localparam int PULL_SHIFT = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = (EPS_W > PULL_W) ? EPS_W : PULL_W;

   localparam logic [CSR_IDX_W-1:0] CSR_DET_EPSILON    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_PULLBACK = CSR_IDX_W'(1);

   // Exact integer widths of the intermediate quantities.
   localparam int E_W    = COORD_W + 1;                 // edges, origin minus vertex
   localparam int DP_W   = COORD_W + PULL_W + 1;        // direction times pullback
   localparam int S_W    = E_W + PULL_SHIFT + 1;        // scaled origin offset
   localparam int HP_W   = COORD_W + E_W;               // products of dir x e2
   localparam int H_W    = HP_W + 1;
   localparam int QP_W   = S_W + E_W;                   // products of s x e1
   localparam int Q_W    = QP_W + 1;
   localparam int H_LO   = H_W / 2;
   localparam int H_HI   = H_W - H_LO;
   localparam int Q_LO   = Q_W / 2;
   localparam int Q_HI   = Q_W - Q_LO;
   localparam int APL_W  = E_W + H_LO + 1;
   localparam int APH_W  = E_W + H_HI;
   localparam int UPL_W  = S_W + H_LO + 1;
   localparam int UPH_W  = S_W + H_HI;
   localparam int VPL_W  = COORD_W + Q_LO + 1;
   localparam int VPH_W  = COORD_W + Q_HI;
   localparam int TPL_W  = E_W + Q_LO + 1;
   localparam int TPH_W  = E_W + Q_HI;
   localparam int A_W    = E_W + H_W + 2;               // determinant
   localparam int DOT_W  = E_W + Q_W + 2;               // U, V and T
   localparam int CMP_W  = DOT_W + 1;
   localparam int NUM_W  = DOT_W + 4;                   // |T| times 16
   localparam int Q_BITS = 31;
   localparam int DIV_W  = A_W + Q_BITS;
   localparam int DIV_STAGES = Q_BITS + 1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [E_W-1:0]     e_type;
   typedef logic signed [DP_W-1:0]    dp_type;
   typedef logic signed [S_W-1:0]     s_type;
   typedef logic signed [HP_W-1:0]    hp_type;
   typedef logic signed [H_W-1:0]     h_type;
   typedef logic signed [QP_W-1:0]    qp_type;
   typedef logic signed [Q_W-1:0]     q_type;
   typedef logic signed [A_W-1:0]     a_type;
   typedef logic signed [DOT_W-1:0]   dot_type;
   typedef logic signed [CMP_W-1:0]   cmp_type;

   // Flags that ride along with an item through the divider.
   typedef struct packed {
      logic keep;   // test reached its end, t is reported
      logic tneg;   // t is negative
      logic tpos;   // t is positive
   } side_type;

endpackage

`default_nettype wire

// ----- rtl/core/rtd_div_pipe.sv -----
// Pipelined restoring divider: a saturation check, then one quotient bit per stage.
// Depends on rtd_pkg for widths and the sideband struct.
`default_nettype none

module rtd_div_pipe (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      adv,
   input  wire logic                      in_valid,
   input  wire logic [rtd_pkg::NUM_W-1:0] in_num,
   input  wire logic [rtd_pkg::A_W-1:0]   in_den,
   input  rtd_pkg::side_type              in_side,
   output logic                           out_valid,
   output logic [rtd_pkg::Q_BITS-1:0]     out_quot,
   output logic                           out_sat,
   output rtd_pkg::side_type              out_side
);

   localparam int NS = rtd_pkg::DIV_STAGES;
   localparam int QB = rtd_pkg::Q_BITS;
   localparam int DW = rtd_pkg::DIV_W;

   logic [DW-1:0]     rem_ff  [NS];
   logic [DW-1:0]     rem_in  [NS];
   logic [DW-1:0]     den_ff  [NS];
   logic [DW-1:0]     den_in  [NS];
   logic [QB-1:0]     quo_ff  [NS];
   logic [QB-1:0]     quo_in  [NS];
   logic              sat_ff  [NS];
   logic              sat_in  [NS];
   rtd_pkg::side_type side_ff [NS];
   rtd_pkg::side_type side_in [NS];
   logic [NS-1:0]     valid_ff;
   logic [NS-1:0]     valid_in;
   logic [DW-1:0]     trial   [NS];

   // Stage 0 only checks whether the quotient reaches 2^31; every later stage
   // settles one quotient bit, from the top down.
   always_comb begin
      rem_in[0]   = DW'(in_num);
      den_in[0]   = DW'(in_den);
      quo_in[0]   = '0;
      trial[0]    = DW'(in_den) << QB;
      sat_in[0]   = (DW'(in_num) >= trial[0]);
      side_in[0]  = in_side;
      valid_in[0] = in_valid;
      for (int j = 1; j < NS; j++) begin
         trial[j]    = den_ff[j-1] << (QB - j);
         den_in[j]   = den_ff[j-1];
         sat_in[j]   = sat_ff[j-1];
         side_in[j]  = side_ff[j-1];
         valid_in[j] = valid_ff[j-1];
         if (rem_ff[j-1] >= trial[j]) begin
            rem_in[j] = rem_ff[j-1] - trial[j];
            quo_in[j] = quo_ff[j-1] | (QB'(1) << (QB - j));
         end else begin
            rem_in[j] = rem_ff[j-1];
            quo_in[j] = quo_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < NS; j++) begin
            rem_ff[j]  <= rem_in[j];
            den_ff[j]  <= den_in[j];
            quo_ff[j]  <= quo_in[j];
            sat_ff[j]  <= sat_in[j];
            side_ff[j] <= side_in[j];
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign out_quot  = quo_ff[NS-1];
   assign out_sat   = sat_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

`default_nettype wire

// ----- rtl/core/ray_triangle_displacement.sv -----
// Top level of the ray / triangle displacement block: Moller-Trumbore in exact fixed point.
// Depends on rtd_pkg and rtd_div_pipe.
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  texel_valid, ray and three vertices
// rsp_      out        rsp_valid / rsp_stall  displacement (Q16.16), hit
// csr_      in         csr_write_en           csr_index, csr_write_data
//
// One beat is accepted per cycle while req_stall is low. A beat passes 42 registers:
// nine arithmetic stages, the 32-stage divider (a saturation check, then one quotient
// bit per stage) and the output register.
// Reset is synchronous and clears the valid bits and both registers.
// When the output beat is stalled, the whole pipeline holds and req_stall is raised;
// nothing is dropped or repeated.

module ray_triangle_displacement (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_texel_valid,
   input  wire logic [3*rtd_pkg::COORD_W-1:0]      req_ray_origin,
   input  wire logic [3*rtd_pkg::COORD_W-1:0]      req_ray_direction,
   input  wire logic [3*rtd_pkg::COORD_W-1:0]      req_vertex_zero,
   input  wire logic [3*rtd_pkg::COORD_W-1:0]      req_vertex_one,
   input  wire logic [3*rtd_pkg::COORD_W-1:0]      req_vertex_two,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [31:0]                      rsp_displacement,
   output logic                                    rsp_hit,
   input  wire logic                               csr_write_en,
   input  wire logic [rtd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rtd_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int CW = rtd_pkg::COORD_W;

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [rtd_pkg::EPS_W-1:0]  det_eps_ff;
   logic [rtd_pkg::PULL_W-1:0] pullback_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         det_eps_ff  <= '0;
         pullback_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            rtd_pkg::CSR_DET_EPSILON: begin
               det_eps_ff <= csr_write_data[rtd_pkg::EPS_W-1:0];
            end
            rtd_pkg::CSR_ORIGIN_PULLBACK: begin
               pullback_ff <= csr_write_data[rtd_pkg::PULL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Flow control: every stage moves together unless the output beat is
   // held. Bubbles travel as cleared valid bits.
   // ------------------------------------------------------------------
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ------------------------------------------------------------------
   // Stage 1: unpack, edges, origin offset and direction times pullback.
   // ------------------------------------------------------------------
   rtd_pkg::coord_type org [3], dir [3], p0 [3], p1 [3], p2 [3];
   rtd_pkg::e_type     e1_c [3], e2_c [3], sa_c [3];
   rtd_pkg::dp_type    dp_c [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         org[k]  = req_ray_origin[k*CW +: CW];
         dir[k]  = req_ray_direction[k*CW +: CW];
         p0[k]   = req_vertex_zero[k*CW +: CW];
         p1[k]   = req_vertex_one[k*CW +: CW];
         p2[k]   = req_vertex_two[k*CW +: CW];
         e1_c[k] = rtd_pkg::e_type'(p1[k]) - rtd_pkg::e_type'(p0[k]);
         e2_c[k] = rtd_pkg::e_type'(p2[k]) - rtd_pkg::e_type'(p0[k]);
         sa_c[k] = rtd_pkg::e_type'(org[k]) - rtd_pkg::e_type'(p0[k]);
         dp_c[k] = rtd_pkg::dp_type'(dir[k]) * $signed({1'b0, pullback_ff});
      end
   end

   logic               s1_valid_ff, s1_tv_ff;
   rtd_pkg::coord_type s1_dir_ff [3];
   rtd_pkg::e_type     s1_e1_ff [3], s1_e2_ff [3], s1_sa_ff [3];
   rtd_pkg::dp_type    s1_dp_ff [3];

   // ------------------------------------------------------------------
   // Stage 2: pulled-back origin offset s and the products of dir x e2.
   // ------------------------------------------------------------------
   rtd_pkg::s_type  s_c [3];
   rtd_pkg::hp_type hp_c [6];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s_c[k] = (rtd_pkg::s_type'(s1_sa_ff[k]) <<< rtd_pkg::PULL_SHIFT)
                  - rtd_pkg::s_type'(s1_dp_ff[k]);
      end
      hp_c[0] = s1_dir_ff[1] * s1_e2_ff[2];
      hp_c[1] = s1_dir_ff[2] * s1_e2_ff[1];
      hp_c[2] = s1_dir_ff[2] * s1_e2_ff[0];
      hp_c[3] = s1_dir_ff[0] * s1_e2_ff[2];
      hp_c[4] = s1_dir_ff[0] * s1_e2_ff[1];
      hp_c[5] = s1_dir_ff[1] * s1_e2_ff[0];
   end

   logic               s2_valid_ff, s2_tv_ff;
   rtd_pkg::coord_type s2_dir_ff [3];
   rtd_pkg::e_type     s2_e1_ff [3], s2_e2_ff [3];
   rtd_pkg::s_type     s2_s_ff [3];
   rtd_pkg::hp_type    s2_hp_ff [6];

   // ------------------------------------------------------------------
   // Stage 3: h = dir x e2 and the products of q = s x e1.
   // ------------------------------------------------------------------
   rtd_pkg::h_type  h_c [3];
   rtd_pkg::qp_type qp_c [6];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         h_c[k] = rtd_pkg::h_type'(s2_hp_ff[2*k]) - rtd_pkg::h_type'(s2_hp_ff[2*k+1]);
      end
      qp_c[0] = s2_s_ff[1] * s2_e1_ff[2];
      qp_c[1] = s2_s_ff[2] * s2_e1_ff[1];
      qp_c[2] = s2_s_ff[2] * s2_e1_ff[0];
      qp_c[3] = s2_s_ff[0] * s2_e1_ff[2];
      qp_c[4] = s2_s_ff[0] * s2_e1_ff[1];
      qp_c[5] = s2_s_ff[1] * s2_e1_ff[0];
   end

   logic               s3_valid_ff, s3_tv_ff;
   rtd_pkg::coord_type s3_dir_ff [3];
   rtd_pkg::e_type     s3_e1_ff [3], s3_e2_ff [3];
   rtd_pkg::s_type     s3_s_ff [3];
   rtd_pkg::h_type     s3_h_ff [3];
   rtd_pkg::qp_type    s3_qp_ff [6];

   // ------------------------------------------------------------------
   // Stage 4: q, and the partial products of e1.h and s.h, with h split in
   // an unsigned low half and a signed high half.
   // ------------------------------------------------------------------
   rtd_pkg::q_type                   q_c [3];
   logic signed [rtd_pkg::APL_W-1:0] apl_c [3];
   logic signed [rtd_pkg::APH_W-1:0] aph_c [3];
   logic signed [rtd_pkg::UPL_W-1:0] upl_c [3];
   logic signed [rtd_pkg::UPH_W-1:0] uph_c [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         q_c[k]   = rtd_pkg::q_type'(s3_qp_ff[2*k]) - rtd_pkg::q_type'(s3_qp_ff[2*k+1]);
         apl_c[k] = s3_e1_ff[k] * $signed({1'b0, s3_h_ff[k][rtd_pkg::H_LO-1:0]});
         aph_c[k] = s3_e1_ff[k] * $signed(s3_h_ff[k][rtd_pkg::H_W-1:rtd_pkg::H_LO]);
         upl_c[k] = s3_s_ff[k] * $signed({1'b0, s3_h_ff[k][rtd_pkg::H_LO-1:0]});
         uph_c[k] = s3_s_ff[k] * $signed(s3_h_ff[k][rtd_pkg::H_W-1:rtd_pkg::H_LO]);
      end
   end

   logic                             s4_valid_ff, s4_tv_ff;
   rtd_pkg::coord_type               s4_dir_ff [3];
   rtd_pkg::e_type                   s4_e2_ff [3];
   rtd_pkg::q_type                   s4_q_ff [3];
   logic signed [rtd_pkg::APL_W-1:0] s4_apl_ff [3];
   logic signed [rtd_pkg::APH_W-1:0] s4_aph_ff [3];
   logic signed [rtd_pkg::UPL_W-1:0] s4_upl_ff [3];
   logic signed [rtd_pkg::UPH_W-1:0] s4_uph_ff [3];

   // ------------------------------------------------------------------
   // Stage 5: join the halves of the a and U terms; partial products of
   // dir.q and e2.q with q split the same way.
   // ------------------------------------------------------------------
   rtd_pkg::a_type                   ac_c [3];
   rtd_pkg::dot_type                 uc_c [3];
   logic signed [rtd_pkg::VPL_W-1:0] vpl_c [3];
   logic signed [rtd_pkg::VPH_W-1:0] vph_c [3];
   logic signed [rtd_pkg::TPL_W-1:0] tpl_c [3];
   logic signed [rtd_pkg::TPH_W-1:0] tph_c [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ac_c[k]  = (rtd_pkg::a_type'(s4_aph_ff[k]) <<< rtd_pkg::H_LO)
                    + rtd_pkg::a_type'(s4_apl_ff[k]);
         uc_c[k]  = (rtd_pkg::dot_type'(s4_uph_ff[k]) <<< rtd_pkg::H_LO)
                    + rtd_pkg::dot_type'(s4_upl_ff[k]);
         vpl_c[k] = s4_dir_ff[k] * $signed({1'b0, s4_q_ff[k][rtd_pkg::Q_LO-1:0]});
         vph_c[k] = s4_dir_ff[k] * $signed(s4_q_ff[k][rtd_pkg::Q_W-1:rtd_pkg::Q_LO]);
         tpl_c[k] = s4_e2_ff[k] * $signed({1'b0, s4_q_ff[k][rtd_pkg::Q_LO-1:0]});
         tph_c[k] = s4_e2_ff[k] * $signed(s4_q_ff[k][rtd_pkg::Q_W-1:rtd_pkg::Q_LO]);
      end
   end

   logic                             s5_valid_ff, s5_tv_ff;
   rtd_pkg::a_type                   s5_ac_ff [3];
   rtd_pkg::dot_type                 s5_uc_ff [3];
   logic signed [rtd_pkg::VPL_W-1:0] s5_vpl_ff [3];
   logic signed [rtd_pkg::VPH_W-1:0] s5_vph_ff [3];
   logic signed [rtd_pkg::TPL_W-1:0] s5_tpl_ff [3];
   logic signed [rtd_pkg::TPH_W-1:0] s5_tph_ff [3];

   // ------------------------------------------------------------------
   // Stage 6: determinant a and U summed; V and T terms joined.
   // ------------------------------------------------------------------
   rtd_pkg::a_type   a_c;
   rtd_pkg::dot_type u_c;
   rtd_pkg::dot_type vc_c [3], tc_c [3];

   always_comb begin
      a_c = s5_ac_ff[0] + s5_ac_ff[1] + s5_ac_ff[2];
      u_c = s5_uc_ff[0] + s5_uc_ff[1] + s5_uc_ff[2];
      for (int k = 0; k < 3; k++) begin
         vc_c[k] = (rtd_pkg::dot_type'(s5_vph_ff[k]) <<< rtd_pkg::Q_LO)
                   + rtd_pkg::dot_type'(s5_vpl_ff[k]);
         tc_c[k] = (rtd_pkg::dot_type'(s5_tph_ff[k]) <<< rtd_pkg::Q_LO)
                   + rtd_pkg::dot_type'(s5_tpl_ff[k]);
      end
   end

   logic             s6_valid_ff, s6_tv_ff;
   rtd_pkg::a_type   s6_a_ff;
   rtd_pkg::dot_type s6_u_ff;
   rtd_pkg::dot_type s6_vc_ff [3], s6_tc_ff [3];

   // ------------------------------------------------------------------
   // Stage 7: V and T summed; the parallel-ray test against det_epsilon.
   // ------------------------------------------------------------------
   rtd_pkg::dot_type     v_c, t_c;
   logic [rtd_pkg::A_W-1:0] a_mag;
   logic                 keep7_c;

   always_comb begin
      v_c     = s6_vc_ff[0] + s6_vc_ff[1] + s6_vc_ff[2];
      t_c     = s6_tc_ff[0] + s6_tc_ff[1] + s6_tc_ff[2];
      a_mag   = s6_a_ff[rtd_pkg::A_W-1] ? -s6_a_ff : s6_a_ff;
      keep7_c = s6_tv_ff && (a_mag > rtd_pkg::A_W'(det_eps_ff));
   end

   logic             s7_valid_ff, s7_keep_ff;
   rtd_pkg::a_type   s7_a_ff;
   rtd_pkg::dot_type s7_u_ff, s7_v_ff, s7_t_ff;

   // ------------------------------------------------------------------
   // Stage 8: a negative determinant flips the sign of a, U, V and T.
   // ------------------------------------------------------------------
   logic             a_neg;
   rtd_pkg::a_type   an_c;
   rtd_pkg::dot_type un_c, vn_c, tn_c;

   always_comb begin
      a_neg = s7_a_ff[rtd_pkg::A_W-1];
      an_c  = a_neg ? -s7_a_ff : s7_a_ff;
      un_c  = a_neg ? -s7_u_ff : s7_u_ff;
      vn_c  = a_neg ? -s7_v_ff : s7_v_ff;
      tn_c  = a_neg ? -s7_t_ff : s7_t_ff;
   end

   logic             s8_valid_ff, s8_keep_ff;
   rtd_pkg::a_type   s8_a_ff;
   rtd_pkg::dot_type s8_u_ff, s8_v_ff, s8_t_ff;

   // ------------------------------------------------------------------
   // Stage 9: barycentric bounds, then the divider operands 16*|T| and a.
   // ------------------------------------------------------------------
   rtd_pkg::cmp_type          a_scaled, u_ext, uv_sum;
   logic                      bary_miss;
   logic [rtd_pkg::DOT_W-1:0] t_mag;
   logic [rtd_pkg::NUM_W-1:0] num_c;
   rtd_pkg::side_type         side_c;

   always_comb begin
      a_scaled  = rtd_pkg::cmp_type'(s8_a_ff) <<< rtd_pkg::PULL_SHIFT;
      u_ext     = rtd_pkg::cmp_type'(s8_u_ff);
      uv_sum    = u_ext + rtd_pkg::cmp_type'(s8_v_ff);
      bary_miss = s8_u_ff[rtd_pkg::DOT_W-1] || (u_ext > a_scaled)
                  || s8_v_ff[rtd_pkg::DOT_W-1] || (uv_sum > a_scaled);
      t_mag     = s8_t_ff[rtd_pkg::DOT_W-1] ? -s8_t_ff : s8_t_ff;
      num_c     = rtd_pkg::NUM_W'(t_mag) << 4;
      side_c.keep = s8_keep_ff && !bary_miss;
      side_c.tneg = s8_t_ff[rtd_pkg::DOT_W-1];
      side_c.tpos = !s8_t_ff[rtd_pkg::DOT_W-1] && (s8_t_ff != '0);
   end

   logic                      s9_valid_ff;
   logic [rtd_pkg::NUM_W-1:0] s9_num_ff;
   logic [rtd_pkg::A_W-1:0]   s9_den_ff;
   rtd_pkg::side_type         s9_side_ff;

   // ------------------------------------------------------------------
   // Valid bits of stages 1 to 9.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
         s9_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
         s8_valid_ff <= s7_valid_ff;
         s9_valid_ff <= s8_valid_ff;
      end
   end

   // Payload of stages 1 to 9 moves with the valid bits.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tv_ff <= req_texel_valid;
         s2_tv_ff <= s1_tv_ff;
         s3_tv_ff <= s2_tv_ff;
         s4_tv_ff <= s3_tv_ff;
         s5_tv_ff <= s4_tv_ff;
         s6_tv_ff <= s5_tv_ff;
         for (int k = 0; k < 3; k++) begin
            s1_dir_ff[k] <= dir[k];
            s1_e1_ff[k]  <= e1_c[k];
            s1_e2_ff[k]  <= e2_c[k];
            s1_sa_ff[k]  <= sa_c[k];
            s1_dp_ff[k]  <= dp_c[k];
            s2_dir_ff[k] <= s1_dir_ff[k];
            s2_e1_ff[k]  <= s1_e1_ff[k];
            s2_e2_ff[k]  <= s1_e2_ff[k];
            s2_s_ff[k]   <= s_c[k];
            s3_dir_ff[k] <= s2_dir_ff[k];
            s3_e1_ff[k]  <= s2_e1_ff[k];
            s3_e2_ff[k]  <= s2_e2_ff[k];
            s3_s_ff[k]   <= s2_s_ff[k];
            s3_h_ff[k]   <= h_c[k];
            s4_dir_ff[k] <= s3_dir_ff[k];
            s4_e2_ff[k]  <= s3_e2_ff[k];
            s4_q_ff[k]   <= q_c[k];
            s4_apl_ff[k] <= apl_c[k];
            s4_aph_ff[k] <= aph_c[k];
            s4_upl_ff[k] <= upl_c[k];
            s4_uph_ff[k] <= uph_c[k];
            s5_ac_ff[k]  <= ac_c[k];
            s5_uc_ff[k]  <= uc_c[k];
            s5_vpl_ff[k] <= vpl_c[k];
            s5_vph_ff[k] <= vph_c[k];
            s5_tpl_ff[k] <= tpl_c[k];
            s5_tph_ff[k] <= tph_c[k];
            s6_vc_ff[k]  <= vc_c[k];
            s6_tc_ff[k]  <= tc_c[k];
         end
         for (int k = 0; k < 6; k++) begin
            s2_hp_ff[k] <= hp_c[k];
            s3_qp_ff[k] <= qp_c[k];
         end
         s6_a_ff    <= a_c;
         s6_u_ff    <= u_c;
         s7_keep_ff <= keep7_c;
         s7_a_ff    <= s6_a_ff;
         s7_u_ff    <= s6_u_ff;
         s7_v_ff    <= v_c;
         s7_t_ff    <= t_c;
         s8_keep_ff <= s7_keep_ff;
         s8_a_ff    <= an_c;
         s8_u_ff    <= un_c;
         s8_v_ff    <= vn_c;
         s8_t_ff    <= tn_c;
         s9_num_ff  <= num_c;
         s9_den_ff  <= s8_a_ff;
         s9_side_ff <= side_c;
      end
   end

   // The stage 9 divisor is taken from stage 8's normalized determinant so
   // that it lines up with the numerator; it is non-negative by then.

   // ------------------------------------------------------------------
   // Divider: t = 16*|T| / a, truncated, with a flag for quotients of 2^31
   // or more.
   // ------------------------------------------------------------------
   logic                         div_valid;
   logic [rtd_pkg::Q_BITS-1:0]   div_quot;
   logic                         div_sat;
   rtd_pkg::side_type            div_side;

   rtd_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s9_valid_ff),
      .in_num    (s9_num_ff),
      .in_den    (s9_den_ff),
      .in_side   (s9_side_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_sat   (div_sat),
      .out_side  (div_side)
   );

   // ------------------------------------------------------------------
   // Output stage: sign, saturation and the zero result of an early miss.
   // A negative t saturates at -2^31 by plain negation of 2^31.
   // ------------------------------------------------------------------
   logic [31:0]        mag32;
   logic signed [31:0] disp_in;
   logic               hit_in;
   logic signed [31:0] rsp_displacement_ff;
   logic               rsp_hit_ff;

   always_comb begin
      mag32 = div_sat ? 32'h8000_0000 : {1'b0, div_quot};
      if (!div_side.keep) begin
         disp_in = '0;
      end else if (div_side.tneg) begin
         disp_in = -$signed(mag32);
      end else if (div_sat) begin
         disp_in = 32'sh7FFF_FFFF;
      end else begin
         disp_in = $signed(mag32);
      end
      hit_in = div_side.keep && div_side.tpos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_displacement_ff <= disp_in;
         rsp_hit_ff          <= hit_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_displacement = rsp_displacement_ff;
   assign rsp_hit          = rsp_hit_ff;

`ifndef SYNTHESIS
   // A hit means t > 0, so the reported displacement cannot be negative.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_displacement[31])
      else $error("hit reported with a negative displacement");

   // An item that missed early must come out as zero with no hit.
   assert property (@(posedge clock) disable iff (reset)
      div_valid && !div_side.keep && adv |=> (rsp_displacement == '0) && !rsp_hit)
      else $error("early miss produced a nonzero result");

   // The sign flags of t are exclusive.
   assert property (@(posedge clock) disable iff (reset)
      div_valid |-> !(div_side.tneg && div_side.tpos))
      else $error("t flagged both negative and positive");
`endif

endmodule

`default_nettype wire

// ----- verif/rtd_checker.sv -----
// Checker for the ray / triangle displacement block: watches both channels and the register port.
// Predicts each response beat in exact wide integer arithmetic; depends on rtd_pkg.
`timescale 1ns / 100ps

module rtd_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_stall,
   input  wire logic                            req_texel_valid,
   input  wire logic [3*rtd_pkg::COORD_W-1:0]   req_ray_origin,
   input  wire logic [3*rtd_pkg::COORD_W-1:0]   req_ray_direction,
   input  wire logic [3*rtd_pkg::COORD_W-1:0]   req_vertex_zero,
   input  wire logic [3*rtd_pkg::COORD_W-1:0]   req_vertex_one,
   input  wire logic [3*rtd_pkg::COORD_W-1:0]   req_vertex_two,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire logic signed [31:0]              rsp_displacement,
   input  wire logic                            rsp_hit,
   input  wire logic                            csr_write_en,
   input  wire logic [rtd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rtd_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                                   pending,
   output int                                   errors
);

   typedef logic signed [127:0] wide_type;
   typedef struct packed {
      logic signed [31:0] disp;
      logic               hit;
   } outcome_type;

   logic [rtd_pkg::EPS_W-1:0]  eps_copy  = '0;
   logic [rtd_pkg::PULL_W-1:0] pull_copy = '0;
   outcome_type                expected_q[$];

   function automatic wide_type comp(logic [3*rtd_pkg::COORD_W-1:0] w, int k);
      wide_type x;
      x = $signed(w[k*rtd_pkg::COORD_W +: rtd_pkg::COORD_W]);
      return x;
   endfunction

   // Exact Moller-Trumbore with the pulled-back origin; only the last division truncates.
   function automatic outcome_type predict_displacement(
         logic tv, logic [3*rtd_pkg::COORD_W-1:0] org, dir, pv0, pv1, pv2,
         logic [rtd_pkg::EPS_W-1:0] eps, logic [rtd_pkg::PULL_W-1:0] pull);
      wide_type o[3], d[3], p0[3], e1[3], e2[3], s[3], h[3], q[3];
      wide_type a, mag, u_n, v_n, t_n, a_sc, epsw, pullw, tmag, num, qm, lim;
      outcome_type r;
      r = '0;
      if (!tv) return r;
      epsw  = eps;
      pullw = pull;
      for (int k = 0; k < 3; k++) begin
         o[k]  = comp(org, k);
         d[k]  = comp(dir, k);
         p0[k] = comp(pv0, k);
         e1[k] = comp(pv1, k) - p0[k];
         e2[k] = comp(pv2, k) - p0[k];
         s[k]  = (o[k] - p0[k]) * 4096 - d[k] * pullw;
      end
      h[0] = d[1] * e2[2] - d[2] * e2[1];
      h[1] = d[2] * e2[0] - d[0] * e2[2];
      h[2] = d[0] * e2[1] - d[1] * e2[0];
      a = e1[0] * h[0] + e1[1] * h[1] + e1[2] * h[2];
      mag = (a < 0) ? -a : a;
      if (mag <= epsw) return r;
      q[0] = s[1] * e1[2] - s[2] * e1[1];
      q[1] = s[2] * e1[0] - s[0] * e1[2];
      q[2] = s[0] * e1[1] - s[1] * e1[0];
      u_n = s[0] * h[0] + s[1] * h[1] + s[2] * h[2];
      v_n = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
      t_n = e2[0] * q[0] + e2[1] * q[1] + e2[2] * q[2];
      if (a < 0) begin
         a = -a;
         u_n = -u_n;
         v_n = -v_n;
         t_n = -t_n;
      end
      a_sc = a * 4096;
      if (u_n < 0 || u_n > a_sc) return r;
      if (v_n < 0 || u_n + v_n > a_sc) return r;
      tmag = (t_n < 0) ? -t_n : t_n;
      num  = tmag * 16;
      lim  = 128'sd2147483648;
      if (num >= a * lim) qm = lim;
      else qm = num / a;
      if (t_n < 0) r.disp = 32'(-qm);
      else r.disp = (qm > lim - 1) ? 32'sh7FFFFFFF : 32'(qm);
      r.hit = (t_n > 0);
      return r;
   endfunction

   assign pending = expected_q.size();

   initial errors = 0;

   always @(posedge clock) begin
      outcome_type got, want;
      if (reset) begin
         eps_copy  <= '0;
         pull_copy <= '0;
      end else begin
         if (csr_write_en) begin
            if (csr_index == rtd_pkg::CSR_DET_EPSILON)
               eps_copy <= csr_write_data[rtd_pkg::EPS_W-1:0];
            else if (csr_index == rtd_pkg::CSR_ORIGIN_PULLBACK)
               pull_copy <= csr_write_data[rtd_pkg::PULL_W-1:0];
         end
         if (req_valid && !req_stall)
            expected_q.insert(expected_q.size(),
               predict_displacement(req_texel_valid, req_ray_origin,
               req_ray_direction, req_vertex_zero, req_vertex_one, req_vertex_two,
               eps_copy, pull_copy));
         if (rsp_valid && !rsp_stall) begin
            got.disp = rsp_displacement;
            got.hit  = rsp_hit;
            if (expected_q.size() == 0) begin
               errors <= errors + 1;
               if (errors < 10)
                  $display("unexpected response beat: displacement %0d hit %0b",
                           got.disp, got.hit);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  errors <= errors + 1;
                  if (errors < 10)
                     $display("mismatch: displacement exp %0d got %0d, hit exp %0b got %0b",
                              want.disp, got.disp, want.hit, got.hit);
               end
            end
         end
      end
   end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the ray / triangle displacement block: stimulus, register writes, verdict.
// Depends on rtd_pkg, ray_triangle_displacement and rtd_checker.
`timescale 1ns / 100ps

module tb_top;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic                           req_texel_valid = 1'b0;
   logic [3*rtd_pkg::COORD_W-1:0]  req_ray_origin = '0;
   logic [3*rtd_pkg::COORD_W-1:0]  req_ray_direction = '0;
   logic [3*rtd_pkg::COORD_W-1:0]  req_vertex_zero = '0;
   logic [3*rtd_pkg::COORD_W-1:0]  req_vertex_one = '0;
   logic [3*rtd_pkg::COORD_W-1:0]  req_vertex_two = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [31:0]             rsp_displacement;
   logic                           rsp_hit;
   logic                           csr_write_en = 1'b0;
   logic [rtd_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [rtd_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   int pending;
   int errors;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int beats_sent = 0;

   // This margin covers the block's own pipeline depth.
   localparam int DRAIN_CYCLES = 60;

   ray_triangle_displacement dut (.*);

   rtd_checker checker_i (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // The receiver stalls at random, at a rate set per phase.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   initial begin
      #2000000;
      $display("[ray_triangle_displacement] ERROR");
      $finish;
   end

   function automatic logic [3*rtd_pkg::COORD_W-1:0] pack3(int x, int y, int z);
      logic [rtd_pkg::COORD_W-1:0] cx, cy, cz;
      cx = rtd_pkg::COORD_W'(x);
      cy = rtd_pkg::COORD_W'(y);
      cz = rtd_pkg::COORD_W'(z);
      return {cz, cy, cx};
   endfunction

   function automatic int rnd_signed(int bits);
      return int'($urandom_range(0, 2 ** (bits + 1))) - 2 ** bits;
   endfunction

   // Presents one request beat and holds it until it is taken. The sender may idle first,
   // but valid is never dropped and raised in the same step.
   task automatic send_beat(logic tv, logic [3*rtd_pkg::COORD_W-1:0] o, d, v0, v1, v2);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_texel_valid   <= tv;
      req_ray_origin    <= o;
      req_ray_direction <= d;
      req_vertex_zero   <= v0;
      req_vertex_one    <= v1;
      req_vertex_two    <= v2;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   // A ray aimed through a point inside a random triangle, so most of these reach the
   // end of the test. Origin sits a few direction lengths back, sometimes in front.
   task automatic send_aimed(logic tv, bit perturb);
      int v0[3], e1[3], e2[3], dr[3], org[3];
      int esc, dsc, wa, wb, steps;
      esc = $urandom_range(4, 16);
      dsc = $urandom_range(4, 14);
      wa = $urandom_range(0, 8);
      wb = $urandom_range(0, 8 - wa);
      steps = int'($urandom_range(0, 18)) - 3;
      for (int k = 0; k < 3; k++) begin
         v0[k] = rnd_signed(16);
         e1[k] = rnd_signed(esc);
         e2[k] = rnd_signed(esc);
         dr[k] = rnd_signed(dsc);
         org[k] = v0[k] + (e1[k] * wa + e2[k] * wb) / 8 - dr[k] * steps;
      end
      if (perturb) org[$urandom_range(0, 2)] += rnd_signed(esc + 1);
      send_beat(tv, pack3(org[0], org[1], org[2]), pack3(dr[0], dr[1], dr[2]),
                pack3(v0[0], v0[1], v0[2]),
                pack3(v0[0] + e1[0], v0[1] + e1[1], v0[2] + e1[2]),
                pack3(v0[0] + e2[0], v0[1] + e2[1], v0[2] + e2[2]));
   endtask

   task automatic send_noise();
      logic [3*rtd_pkg::COORD_W-1:0] f[5];
      for (int k = 0; k < 5; k++) f[k] = (3*rtd_pkg::COORD_W)'({$urandom, $urandom});
      send_beat(1'($urandom_range(1)), f[0], f[1], f[2], f[3], f[4]);
   endtask

   // Waits out every outstanding beat, plus the pipeline depth, before a register write.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [rtd_pkg::CSR_IDX_W-1:0] idx,
                            logic [rtd_pkg::CSR_DATA_W-1:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_directed();
      logic [3*rtd_pkg::COORD_W-1:0] ones, zeros, maxc, minc, unit_x, unit_y, unit_z;
      ones   = '1;
      zeros  = '0;
      maxc   = pack3(32'h7FFFF, 32'h7FFFF, 32'h7FFFF);
      minc   = pack3(-32'h80000, -32'h80000, -32'h80000);
      unit_x = pack3(1, 0, 0);
      unit_y = pack3(0, 1, 0);
      unit_z = pack3(0, 0, 1);
      // Texel without a triangle, with every other bit set.
      send_beat(1'b0, ones, ones, ones, ones, ones);
      // Degenerate triangle: the determinant is zero, a parallel ray.
      send_beat(1'b1, zeros, zeros, zeros, zeros, zeros);
      send_beat(1'b1, maxc, maxc, maxc, maxc, maxc);
      send_beat(1'b1, minc, minc, minc, minc, minc);
      send_beat(1'b1, minc, maxc, minc, maxc, pack3(32'h7FFFF, -32'h80000, 0));
      // Tiny triangle far along the ray: t overflows in both directions.
      send_beat(1'b1, pack3(0, 0, -32'h80000), unit_z, zeros, unit_x, unit_y);
      send_beat(1'b1, pack3(0, 0, 32'h7FFFF), unit_z, zeros, unit_x, unit_y);
      // Ray straight through a corner, and two just off the triangle.
      send_beat(1'b1, pack3(0, 0, -4096), pack3(0, 0, 4096), zeros,
                pack3(4096, 0, 0), pack3(0, 4096, 0));
      send_beat(1'b1, pack3(4097, 0, -4096), pack3(0, 0, 4096), zeros,
                pack3(4096, 0, 0), pack3(0, 4096, 0));
      send_beat(1'b1, pack3(-1, 100, -4096), pack3(0, 0, 4096), zeros,
                pack3(4096, 0, 0), pack3(0, 4096, 0));
      // Origin behind the triangle: t negative, hit clear. Origin on the plane: t zero.
      send_beat(1'b1, pack3(100, 100, 8192), pack3(0, 0, 4096), zeros,
                pack3(4096, 0, 0), pack3(0, 4096, 0));
      send_beat(1'b1, pack3(100, 100, 0), pack3(0, 0, 4096), zeros,
                pack3(4096, 0, 0), pack3(0, 4096, 0));
      // Reversed winding gives a positive determinant.
      send_beat(1'b1, pack3(100, 100, -4096), pack3(0, 0, 4096), zeros,
                pack3(0, 4096, 0), pack3(4096, 0, 0));
      for (int k = 0; k < 8; k++) send_aimed(1'b1, 1'b0);
   endtask

   task automatic run_random(int count);
      int pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 65) send_aimed(1'b1, 1'b0);
         else if (pick < 75) send_aimed(1'b1, 1'b1);
         else if (pick < 80) send_aimed(1'b0, 1'b0);
         else send_noise();
      end
   endtask

   initial begin
      logic [rtd_pkg::CSR_DATA_W-1:0] eps_set[6];
      logic [rtd_pkg::CSR_DATA_W-1:0] pull_set[6];
      eps_set  = '{20'd0, 20'hFFFFF, 20'd0, 20'd0, 20'd0, 20'd0};
      pull_set = '{20'd0, 20'hFFFFF, 20'd4095, 20'd0, 20'd0, 20'd0};
      for (int k = 3; k < 6; k++) begin
         eps_set[k]  = rtd_pkg::CSR_DATA_W'($urandom);
         pull_set[k] = rtd_pkg::CSR_DATA_W'($urandom);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Six phases; each pair of phases shares one idling pattern, each phase its own
      // register setting. The first phase runs with the reset values of both registers.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph / 2)
            0: begin send_idle_pct = 32; recv_idle_pct = 74; end
            1: begin send_idle_pct = 74; recv_idle_pct = 32; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (ph > 0) begin
            drain();
            write_reg(rtd_pkg::CSR_DET_EPSILON, eps_set[ph]);
            write_reg(rtd_pkg::CSR_ORIGIN_PULLBACK, pull_set[ph]);
            // Indexes past the register list must leave both registers alone.
            write_reg(rtd_pkg::CSR_IDX_W'(2), rtd_pkg::CSR_DATA_W'($urandom));
            write_reg(rtd_pkg::CSR_IDX_W'(3), rtd_pkg::CSR_DATA_W'($urandom));
         end
         if (ph == 0) run_directed();
         run_random(67);
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d request beats over six register settings and three idle patterns,",
               beats_sent);
      $display("including parallel rays, barycentric misses, negative t and saturation.");
      if (errors == 0) begin
         $display("[ray_triangle_displacement] OK");
      end else begin
         $display("[ray_triangle_displacement] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/rtd_pkg.sv
rtl/core/rtd_div_pipe.sv
rtl/core/ray_triangle_displacement.sv
verif/rtd_checker.sv
verif/tb_top.sv
